// ===== hw/rtl/cfa_pkg.sv =====
package cfa_pkg;

   // Register indexes on the configuration port
   localparam logic [1:0] CSR_BOX_EDGE  = 2'd0;
   localparam logic [1:0] CSR_STIFFNESS = 2'd1;
   localparam logic [1:0] CSR_DAMPING   = 2'd2;

   // Register reset values
   localparam logic [30:0] BOX_EDGE_RST  = 31'd65536;
   localparam logic [15:0] STIFFNESS_RST = 16'd10000;
   localparam logic [15:0] DAMPING_RST   = 16'd30;

   // Iteration counts of the root steps and the shared divide steps
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 35;

   // Datapath operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SQ,
      OP_R2,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_CLR_VR,
      OP_MUL_V,
      OP_MUL_Q,
      OP_MUL_W,
      OP_DIV_STEP,
      OP_ACC_VR,
      OP_SAVE_Q,
      OP_FMUL,
      OP_FSUB,
      OP_SUM,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
   } dp_cmd_type;

   typedef struct packed {
      logic skip;
      logic last;
      logic no_contact;
      logic d_zero;
      logic out_busy;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SQ,
      S_CHECK,
      S_SQRT,
      S_ZCHK,
      S_VMUL,
      S_VDIV,
      S_VACC,
      S_QMUL,
      S_QDIV,
      S_QSAVE,
      S_WMUL,
      S_WDIV,
      S_FMUL,
      S_FSUB,
      S_FSUM,
      S_DONE
   } ctrl_state_type;

endpackage

// ===== hw/rtl/contact_force_accumulator.sv =====
// Contact force accumulator. Each request transfer is one neighbour of a
// centre particle; the block wraps dx and dy once into the periodic box,
// and when the pair overlaps it adds a spring-dashpot force to three Q32.16
// sums that saturate. A request with tlast high produces one response with
// the sums and the clip flag, then clears them; a skipped last item still
// responds. A skipped item, one with no contact and one with coincident
// centres end early; on contact an item runs a 32-step bit-serial square
// root, then nine 35-step divisions (radial velocity, overlap and damping
// terms for each axis) on one shared divider, one quotient bit
// per cycle. Requests are taken one at a time; the next one is accepted
// while a response still waits in the output register, but a last item
// holds in the block until that register is free. Configuration is
// written through csr_we, csr_index and csr_wdata while the block is idle.
module contact_force_accumulator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // dx, dy, dz, dvx, dvy, dvz, contact_distance, zero pad
   input  logic [223:0] req_tdata,
   // skip_self
   input  logic         req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, force_z
   output logic [143:0] rsp_tdata,
   // saturated
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [30:0]  csr_wdata
);
   import cfa_pkg::*;

   logic [30:0]   box_edge_ff;
   logic [15:0]   stiffness_ff;
   logic [15:0]   damping_ff;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         box_edge_ff  <= BOX_EDGE_RST;
         stiffness_ff <= STIFFNESS_RST;
         damping_ff   <= DAMPING_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BOX_EDGE:  box_edge_ff  <= csr_wdata;
            CSR_STIFFNESS: stiffness_ff <= csr_wdata[15:0];
            CSR_DAMPING:   damping_ff   <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   cfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cfa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .box_edge         (box_edge_ff),
      .spring_stiffness (stiffness_ff),
      .damping          (damping_ff),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser)
   );

endmodule

// ===== hw/rtl/cfa_datapath.sv =====
module cfa_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  cfa_pkg::dp_cmd_type    cmd,
   output cfa_pkg::dp_status_type status,
   input  logic [30:0]            box_edge,
   input  logic [15:0]            spring_stiffness,
   input  logic [15:0]            damping,
   // dx, dy, dz, dvx, dvy, dvz, contact_distance, zero pad
   input  logic [223:0]           req_tdata,
   // skip_self
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // force_x, force_y, force_z
   output logic [143:0]           rsp_tdata,
   // saturated
   output logic                   rsp_tuser
);
   import cfa_pkg::*;

   localparam logic signed [51:0] SUM_MAX = 52'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [51:0] SUM_MIN = -52'sh0_8000_0000_0000;

   function automatic logic signed [32:0] wrap_pos(input logic [31:0] v,
                                                   input logic [30:0] len);
      logic signed [33:0] v34;
      logic signed [33:0] two;
      logic signed [33:0] l34;
      begin
         v34 = {{2{v[31]}}, v};
         two = v34 <<< 1;
         l34 = {3'b000, len};
         if (two > l34) begin
            wrap_pos = 33'(v34 - l34);
         end else if (two < -l34) begin
            wrap_pos = 33'(v34 + l34);
         end else begin
            wrap_pos = 33'(v34);
         end
      end
   endfunction

   logic signed [32:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic [30:0]        r_ff;
   logic               skip_ff;
   logic               last_ff;
   logic [63:0]        d2_ff;
   logic [61:0]        r2_ff;
   logic [31:0]        root_ff;
   logic [33:0]        srem_ff;
   logic signed [35:0] vr_ff;
   logic [30:0]        rem_ff;
   logic [34:0]        quo_ff;
   logic               sign_ff;
   logic signed [35:0] qv_ff;
   logic signed [51:0] kq_ff;
   logic signed [51:0] gw_ff;
   logic signed [51:0] f_ff;
   logic signed [47:0] sum_ff [3];
   logic               clip_ff;
   logic               out_valid_ff;
   logic [143:0]       out_data_ff;
   logic               out_sat_ff;

   logic [1:0]         ax;
   logic signed [32:0] cur_pos;
   logic signed [31:0] cur_vel;
   logic [31:0]        pmag;
   logic [31:0]        vmag;
   logic [34:0]        vr_mag;
   logic [34:0]        mul_a;
   logic [31:0]        mul_b;
   logic [66:0]        prod;
   logic [35:0]        s_rem_try;
   logic [35:0]        s_trial;
   logic               s_ge;
   logic [31:0]        d_trial;
   logic               d_ge;
   logic signed [35:0] squo;
   logic signed [51:0] sum_ext;
   logic signed [51:0] sum_t;

   // Select the axis operand
   assign ax      = (cmd.axis == 2'd3) ? 2'd0 : cmd.axis;
   assign cur_pos = pos_ff[ax];
   assign cur_vel = vel_ff[ax];
   assign pmag    = cur_pos[32] ? 32'(-cur_pos) : 32'(cur_pos);
   assign vmag    = cur_vel[31] ? 32'(-33'(cur_vel)) : 32'(cur_vel);
   assign vr_mag  = vr_ff[35] ? 35'(-vr_ff) : 35'(vr_ff);

   // Shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SQ: begin
            mul_a = {3'b000, pmag};
            mul_b = pmag;
         end
         OP_R2: begin
            mul_a = {4'b0000, r_ff};
            mul_b = {1'b0, r_ff};
         end
         OP_MUL_V: begin
            mul_a = {3'b000, vmag};
            mul_b = pmag;
         end
         OP_MUL_Q: begin
            mul_a = {3'b000, 32'({1'b0, r_ff} - root_ff)};
            mul_b = pmag;
         end
         OP_MUL_W: begin
            mul_a = vr_mag;
            mul_b = pmag;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // One root digit per step
   assign s_rem_try = {srem_ff, d2_ff[63:62]};
   assign s_trial   = {2'b00, root_ff, 2'b01};
   assign s_ge      = s_rem_try >= s_trial;

   // One quotient bit per step
   assign d_trial = {rem_ff, quo_ff[34]};
   assign d_ge    = d_trial >= root_ff;
   assign squo    = sign_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

   // Saturating add of the pair force
   assign sum_ext = 52'(sum_ff[ax]);
   assign sum_t   = sum_ext + f_ff;

   // Operand and arithmetic registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            pos_ff[0] <= wrap_pos(req_tdata[31:0], box_edge);
            pos_ff[1] <= wrap_pos(req_tdata[63:32], box_edge);
            pos_ff[2] <= {req_tdata[95], req_tdata[95:64]};
            vel_ff[0] <= req_tdata[127:96];
            vel_ff[1] <= req_tdata[159:128];
            vel_ff[2] <= req_tdata[191:160];
            r_ff      <= req_tdata[222:192];
            skip_ff   <= req_tuser;
            last_ff   <= req_tlast;
            d2_ff     <= '0;
         end
         OP_SQ:        d2_ff <= d2_ff + prod[63:0];
         OP_R2:        r2_ff <= prod[61:0];
         OP_SQRT_INIT: begin
            root_ff <= '0;
            srem_ff <= '0;
         end
         OP_SQRT_STEP: begin
            srem_ff <= s_ge ? 34'(s_rem_try - s_trial) : 34'(s_rem_try);
            root_ff <= {root_ff[30:0], s_ge};
            d2_ff   <= {d2_ff[61:0], 2'b00};
         end
         OP_CLR_VR:    vr_ff <= '0;
         OP_MUL_V, OP_MUL_Q, OP_MUL_W: begin
            rem_ff <= {2'b00, prod[63:35]};
            quo_ff <= prod[34:0];
            if (cmd.op == OP_MUL_V) begin
               sign_ff <= cur_vel[31] ^ cur_pos[32];
            end else if (cmd.op == OP_MUL_Q) begin
               sign_ff <= cur_pos[32];
            end else begin
               sign_ff <= vr_ff[35] ^ cur_pos[32];
            end
         end
         OP_DIV_STEP: begin
            rem_ff <= d_ge ? 31'(d_trial - root_ff) : d_trial[30:0];
            quo_ff <= {quo_ff[33:0], d_ge};
         end
         OP_ACC_VR:    vr_ff <= vr_ff + squo;
         OP_SAVE_Q:    qv_ff <= squo;
         OP_FMUL: begin
            kq_ff <= $signed({36'd0, spring_stiffness}) * $signed({{16{qv_ff[35]}}, qv_ff});
            gw_ff <= $signed({36'd0, damping}) * $signed({{16{squo[35]}}, squo});
         end
         OP_FSUB:      f_ff <= kq_ff - gw_ff;
         default: begin
         end
      endcase
   end

   // Force sums, clip flag and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         sum_ff[2]    <= '0;
         clip_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_SUM) begin
            if (sum_t > SUM_MAX) begin
               sum_ff[ax] <= SUM_MAX[47:0];
               clip_ff    <= 1'b1;
            end else if (sum_t < SUM_MIN) begin
               sum_ff[ax] <= SUM_MIN[47:0];
               clip_ff    <= 1'b1;
            end else begin
               sum_ff[ax] <= sum_t[47:0];
            end
         end else if (cmd.op == OP_EMIT) begin
            sum_ff[0] <= '0;
            sum_ff[1] <= '0;
            sum_ff[2] <= '0;
            clip_ff   <= 1'b0;
         end
         if (cmd.op == OP_EMIT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         out_data_ff <= {sum_ff[2], sum_ff[1], sum_ff[0]};
         out_sat_ff  <= clip_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sat_ff;

   assign status.skip       = skip_ff;
   assign status.last       = last_ff;
   assign status.no_contact = d2_ff >= {2'b00, r2_ff};
   assign status.d_zero     = root_ff == '0;
   assign status.out_busy   = out_valid_ff & ~rsp_tready;

   // Issuing a result leaves it valid, with the clip flag and the x sum cleared
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |=> rsp_tvalid && !clip_ff && sum_ff[0] == '0)
      else $error("sums not cleared after result");

   // A stalled result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> cmd.op != OP_EMIT)
      else $error("result overwritten while stalled");

endmodule

// ===== hw/rtl/cfa_ctrl.sv =====
module cfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output cfa_pkg::dp_cmd_type    cmd,
   input  cfa_pkg::dp_status_type status
);
   import cfa_pkg::*;

   localparam logic [5:0] SQRT_LAST = 6'(SQRT_STEPS - 1);
   localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);

   ctrl_state_type state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [1:0]     axis_ff, axis_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
      end
   end

   // Sequence one neighbour through the datapath
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      axis_in    = axis_ff;
      cmd.op     = OP_NONE;
      cmd.axis   = axis_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               axis_in  = 2'd0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (status.skip) begin
               state_in = S_DONE;
            end else if (axis_ff == 2'd3) begin
               cmd.op   = OP_R2;
               state_in = S_CHECK;
            end else begin
               cmd.op  = OP_SQ;
               axis_in = axis_ff + 2'd1;
            end
         end
         S_CHECK: begin
            if (status.no_contact) begin
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_SQRT_INIT;
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               state_in = S_ZCHK;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_ZCHK: begin
            if (status.d_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_CLR_VR;
               axis_in  = 2'd0;
               state_in = S_VMUL;
            end
         end
         S_VMUL: begin
            cmd.op   = OP_MUL_V;
            cnt_in   = '0;
            state_in = S_VDIV;
         end
         S_VDIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_VACC;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_VACC: begin
            cmd.op = OP_ACC_VR;
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               state_in = S_QMUL;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_VMUL;
            end
         end
         S_QMUL: begin
            cmd.op   = OP_MUL_Q;
            cnt_in   = '0;
            state_in = S_QDIV;
         end
         S_QDIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_QSAVE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_QSAVE: begin
            cmd.op   = OP_SAVE_Q;
            state_in = S_WMUL;
         end
         S_WMUL: begin
            cmd.op   = OP_MUL_W;
            cnt_in   = '0;
            state_in = S_WDIV;
         end
         S_WDIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_FMUL;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         S_FMUL: begin
            cmd.op   = OP_FMUL;
            state_in = S_FSUB;
         end
         S_FSUB: begin
            cmd.op   = OP_FSUB;
            state_in = S_FSUM;
         end
         S_FSUM: begin
            cmd.op = OP_SUM;
            if (axis_ff == 2'd2) begin
               state_in = S_DONE;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_QMUL;
            end
         end
         S_DONE: begin
            // Hold a last item until the result register is free
            if (!status.last) begin
               state_in = S_IDLE;
            end else if (!status.out_busy) begin
               cmd.op   = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> !status.out_busy)
      else $error("result issued into a busy output register");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_SQ && axis_ff == 2'd0)
      else $error("accepted item did not start");

   a_sqrt_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SQRT && cnt_ff == SQRT_LAST |=> state_ff == S_ZCHK)
      else $error("root iteration count wrong");

endmodule
